### sv/mbrtu_pkg.sv
package mbrtu_pkg;

    // command codes carried in the input word's tuser
    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // frame status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED    = 3'd0,
        ST_CRC_ERROR   = 3'd1,
        ST_WRONG_LEN   = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_OVERFLOW    = 3'd4
    } status_t;

    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  SILENCE_RESET = 8'd200;
    localparam logic [7:0]  FUNC_READ_IN  = 8'd4;
    localparam logic [7:0]  FUNC_WRITE    = 8'd6;
    localparam int          ACCEPT_LEN    = 8;

    // one byte of reflected crc-16, unrolled over the eight bit steps
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/modbus_rtu_frame_receiver_core.sv
// latency: a word is registered at the input and processed in the next cycle, unless it
//   waits behind an untaken result; any result shows on the master side the cycle after that
// throughput: one input word per cycle; the single output register holds a result
//   until taken, and only a word that would give a new result waits behind it
// reset: synchronous active-low aresetn clears all frame state, loads silence_ticks
//   with 200 and empties the input and output registers
module modbus_rtu_frame_receiver_core #(
    parameter int MAX_FRAME_BYTES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: silence_ticks
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] transmitting, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] crc_ok, [5:1] byte_count, [13:6] station_address,
                                   // [21:14] function_code, [23:22] zero
    output logic [2:0]  m_tuser    // [2:0] status
);
    import mbrtu_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_ACC = CNT_W'(ACCEPT_LEN);

    // configuration register
    logic [7:0] silence_ticks_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       in_tx_reg;

    // frame state
    logic [15:0]      crc_reg, crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       timer_reg, timer_next;
    logic             open_reg, open_next;
    logic             ready_reg, ready_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       second_reg, second_next;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_status_reg, out_status_next;
    logic        out_ok_reg, out_ok_next;
    logic [4:0]  out_count_reg, out_count_next;
    logic [7:0]  out_addr_reg;
    logic [7:0]  out_func_reg;

    logic             gives_result;
    logic             advance;
    logic [CNT_W+4:0] count_ext;

    assign cfg_ready = 1'b1;

    // does the held word finish a frame
    assign gives_result = (cmd_t'(in_cmd_reg) == CMD_TICK) && (timer_reg == 8'd0)
                          && open_reg && !ready_reg;
    assign advance  = in_valid_reg && (!gives_result || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // frame state update for the held word
    always_comb begin
        crc_next    = crc_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        open_next   = open_reg;
        ready_next  = ready_reg;
        ovf_next    = ovf_reg;
        first_next  = first_reg;
        second_next = second_reg;
        case (cmd_t'(in_cmd_reg))
            CMD_BYTE: begin
                if (!in_tx_reg && !ready_reg) begin
                    logic [15:0]      crc_base;
                    logic [CNT_W-1:0] cnt_base;
                    logic             ovf_base;
                    crc_base = crc_reg;
                    cnt_base = count_reg;
                    ovf_base = ovf_reg;
                    // silence already elapsed: start a fresh frame
                    if (timer_reg == 8'd0) begin
                        crc_base    = CRC_INIT;
                        cnt_base    = '0;
                        ovf_base    = 1'b0;
                        first_next  = 8'd0;
                        second_next = 8'd0;
                        open_next   = 1'b1;
                    end
                    timer_next = silence_ticks_reg;
                    if (cnt_base == CNT_W'(0)) begin
                        first_next = in_byte_reg;
                    end else if (cnt_base == CNT_W'(1)) begin
                        second_next = in_byte_reg;
                    end
                    crc_next = crc_fold(crc_base, in_byte_reg);
                    if (cnt_base < CNT_MAX) begin
                        count_next = cnt_base + CNT_W'(1);
                        ovf_next   = ovf_base;
                    end else begin
                        count_next = cnt_base;
                        ovf_next   = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                if (timer_reg != 8'd0) begin
                    timer_next = timer_reg - 8'd1;
                end else if (open_reg && !ready_reg) begin
                    ready_next = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (ready_reg) begin
                    ready_next = 1'b0;
                    open_next  = 1'b0;
                    crc_next   = CRC_INIT;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // result fields of a finished frame
    assign count_ext = {5'd0, count_reg};
    always_comb begin
        out_ok_next    = (crc_reg == 16'h0000);
        out_count_next = count_ext[4:0];
        if (ovf_reg) begin
            out_status_next = ST_OVERFLOW;
        end else if (!out_ok_next) begin
            out_status_next = ST_CRC_ERROR;
        end else if (second_reg != FUNC_READ_IN && second_reg != FUNC_WRITE) begin
            out_status_next = ST_UNSUPPORTED;
        end else if (count_reg != CNT_ACC) begin
            out_status_next = ST_WRONG_LEN;
        end else begin
            out_status_next = ST_ACCEPTED;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_ticks_reg <= SILENCE_RESET;
            in_valid_reg      <= 1'b0;
            crc_reg           <= CRC_INIT;
            count_reg         <= '0;
            timer_reg         <= 8'd0;
            open_reg          <= 1'b0;
            ready_reg         <= 1'b0;
            ovf_reg           <= 1'b0;
            first_reg         <= 8'd0;
            second_reg        <= 8'd0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                silence_ticks_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                crc_reg    <= crc_next;
                count_reg  <= count_next;
                timer_reg  <= timer_next;
                open_reg   <= open_next;
                ready_reg  <= ready_next;
                ovf_reg    <= ovf_next;
                first_reg  <= first_next;
                second_reg <= second_next;
            end
            if (advance && gives_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_tx_reg   <= s_tdata[8];
        end
        if (advance && gives_result) begin
            out_status_reg <= out_status_next;
            out_ok_reg     <= out_ok_next;
            out_count_reg  <= out_count_next;
            out_addr_reg   <= first_reg;
            out_func_reg   <= second_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_func_reg, out_addr_reg, out_count_reg, out_ok_reg};

    // a ready frame is always an open one
    a_ready_open: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> open_reg)
        else $error("frame ready without open frame");

    // overflow only with a full count
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == CNT_MAX))
        else $error("overflow flag with count below maximum");

    // a finished frame leaves the frame held and a result shown
    a_result_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && gives_result) |=> (ready_reg && out_valid_reg))
        else $error("finished frame not held or result not shown");

    // a word that would give a result never overwrites an untaken one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && in_valid_reg && gives_result) |-> !advance)
        else $error("pending result overwritten");

endmodule
